// ===== hw/rtl/vdu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vdu_pkg;

  localparam int MAX_LEN   = 4096;
  localparam int ELEM_BITS = 16;
  localparam int DIST_BITS = 31;
  localparam int CNT_BITS  = $clog2(MAX_LEN + 2);
  localparam int LEN_BITS  = $clog2(MAX_LEN);
  // Sums sized for MAX_LEN full-scale elements, so they never overflow
  localparam int ABS_W     = ELEM_BITS + 1 + LEN_BITS;
  localparam int SQ_W      = 2 * ELEM_BITS + LEN_BITS + 1;
  localparam int DOT_W     = 2 * ELEM_BITS + LEN_BITS;
  localparam int NRM_W     = 2 * ELEM_BITS + LEN_BITS - 1;
  localparam int MAG_W     = DOT_W - 1;
  localparam int PROD_W    = 2 * (ELEM_BITS + 1);
  localparam int WIDE_W    = 2 * MAG_W + 1;
  localparam int ROOT_W    = 2 * DIST_BITS - 1;
  localparam int QUO_W     = 28;
  localparam int COS_ONE   = 16384;

  localparam logic [1:0] MET_L1 = 2'd0;
  localparam logic [1:0] MET_L2 = 2'd1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MISMATCH  = 2'd1,
    ST_ZERO_NORM = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_e;

  typedef struct packed {
    logic signed [ELEM_BITS-1:0] elem_a;
    logic signed [ELEM_BITS-1:0] elem_b;
    logic                        a_last;
    logic                        b_last;
  } in_item_t;

  typedef struct packed {
    logic signed [DIST_BITS-1:0] distance;
    status_e                     status;
  } out_item_t;

  typedef struct packed {
    logic       step_en;
    logic [1:0] step;
    logic       clr;
  } acc_ctl_t;

  typedef struct packed {
    logic start;
    logic cosine;
  } cls_req_t;

  typedef struct packed {
    logic                 done;
    logic [DIST_BITS-1:0] root;
  } cls_rsp_t;

endpackage

`default_nettype wire

// ===== hw/rtl/vdu_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface vdu_in_if;
  import vdu_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdu_out_if;
  import vdu_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface vdu_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/vdu_acc.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vdu_acc import vdu_pkg::*; (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  acc_ctl_t                    ctl_i,
  input  logic signed [ELEM_BITS-1:0] a_i,
  input  logic signed [ELEM_BITS-1:0] b_i,
  output logic [ABS_W-1:0]            abs_sum_o,
  output logic [SQ_W-1:0]             sq_sum_o,
  output logic signed [DOT_W-1:0]     dot_sum_o,
  output logic [NRM_W-1:0]            na_sum_o,
  output logic [NRM_W-1:0]            nb_sum_o,
  output logic [CNT_BITS-1:0]         count_o
);

  logic signed [ELEM_BITS:0]  a_x, b_x, diff;
  logic [ELEM_BITS:0]         adiff;
  logic signed [ELEM_BITS:0]  ma, mb;
  logic signed [PROD_W-1:0]   prod;
  logic                       room;

  logic [ABS_W-1:0]        abs_q;
  logic [SQ_W-1:0]         sq_q;
  logic signed [DOT_W-1:0] dot_q;
  logic [NRM_W-1:0]        na_q, nb_q;
  logic [CNT_BITS-1:0]     cnt_q;

  assign a_x   = {a_i[ELEM_BITS-1], a_i};
  assign b_x   = {b_i[ELEM_BITS-1], b_i};
  assign diff  = a_x - b_x;
  assign adiff = diff[ELEM_BITS] ? (ELEM_BITS+1)'(-diff) : (ELEM_BITS+1)'(diff);
  assign room  = cnt_q < CNT_BITS'(MAX_LEN);

  // One shared multiplier, one product per step
  always_comb begin
    case (ctl_i.step)
      2'd0:    begin ma = diff; mb = diff; end
      2'd1:    begin ma = a_x;  mb = b_x;  end
      2'd2:    begin ma = a_x;  mb = a_x;  end
      default: begin ma = b_x;  mb = b_x;  end
    endcase
  end

  assign prod = ma * mb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      abs_q <= '0;
      sq_q  <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else if (ctl_i.clr) begin
      abs_q <= '0;
      sq_q  <= '0;
      dot_q <= '0;
      na_q  <= '0;
      nb_q  <= '0;
      cnt_q <= '0;
    end else if (ctl_i.step_en) begin
      case (ctl_i.step)
        2'd0: begin
          if (room) begin
            abs_q <= abs_q + ABS_W'(adiff);
            sq_q  <= sq_q + SQ_W'(prod[PROD_W-3:0]);
          end
        end
        2'd1: begin
          if (room) dot_q <= dot_q + {{(DOT_W-PROD_W){prod[PROD_W-1]}}, prod};
        end
        2'd2: begin
          if (room) na_q <= na_q + NRM_W'(prod[PROD_W-3:0]);
        end
        default: begin
          if (room) nb_q <= nb_q + NRM_W'(prod[PROD_W-3:0]);
          if (cnt_q <= CNT_BITS'(MAX_LEN)) cnt_q <= cnt_q + 1'b1;
        end
      endcase
    end
  end

  assign abs_sum_o = abs_q;
  assign sq_sum_o  = sq_q;
  assign dot_sum_o = dot_q;
  assign na_sum_o  = na_q;
  assign nb_sum_o  = nb_q;
  assign count_o   = cnt_q;

endmodule

`default_nettype wire

// ===== hw/rtl/vdu_close.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vdu_close import vdu_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cls_req_t         req_i,
  input  logic [SQ_W-1:0]  sq_i,
  input  logic [MAG_W-1:0] dmag_i,
  input  logic [NRM_W-1:0] na_i,
  input  logic [NRM_W-1:0] nb_i,
  output cls_rsp_t         rsp_o
);

  localparam int W = WIDE_W;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL_P, S_MUL_Q, S_CMP, S_DIV, S_SQRT, S_DONE
  } state_e;

  state_e            state_q;
  logic [W-1:0]      work_q, p_q;
  logic [MAG_W-1:0]  mpl_q;
  logic [QUO_W-1:0]  quo_q;
  logic [ROOT_W-1:0] root_q, bit_q;
  logic [5:0]        cnt_q;

  logic [MAG_W-1:0]  mcand;
  logic [W-1:0]      opa, opb;
  logic              sub;
  logic [W:0]        sum;
  logic              ge;

  assign mcand = (state_q == S_MUL_P) ? MAG_W'(na_i) : dmag_i;

  // Shared wide adder / subtractor
  always_comb begin
    opa = '0;
    opb = '0;
    sub = 1'b0;
    case (state_q)
      S_MUL_P, S_MUL_Q: begin
        opa = work_q << 1;
        opb = mpl_q[MAG_W-1] ? W'(mcand) : '0;
      end
      S_CMP: begin
        opa = work_q;
        opb = p_q;
        sub = 1'b1;
      end
      S_DIV: begin
        opa = work_q << 1;
        opb = p_q;
        sub = 1'b1;
      end
      S_SQRT: begin
        opa = work_q;
        opb = W'(root_q | bit_q);
        sub = 1'b1;
      end
      default: ;
    endcase
  end

  assign sum = {1'b0, opa} + {1'b0, (sub ? ~opb : opb)} + (W+1)'(sub);
  assign ge  = sum[W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      work_q  <= '0;
      p_q     <= '0;
      mpl_q   <= '0;
      quo_q   <= '0;
      root_q  <= '0;
      bit_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (req_i.start) begin
            if (req_i.cosine) begin
              work_q  <= '0;
              mpl_q   <= MAG_W'(nb_i);
              cnt_q   <= 6'(MAG_W - 1);
              state_q <= S_MUL_P;
            end else begin
              work_q  <= W'({sq_i, 16'b0});
              root_q  <= '0;
              bit_q   <= ROOT_W'(1) << (ROOT_W - 1);
              cnt_q   <= 6'((ROOT_W - 1) / 2);
              state_q <= S_SQRT;
            end
          end
        end
        S_MUL_P: begin
          work_q <= sum[W-1:0];
          mpl_q  <= mpl_q << 1;
          if (cnt_q == '0) begin
            p_q     <= sum[W-1:0];
            work_q  <= '0;
            mpl_q   <= dmag_i;
            cnt_q   <= 6'(MAG_W - 1);
            state_q <= S_MUL_Q;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_MUL_Q: begin
          work_q <= sum[W-1:0];
          mpl_q  <= mpl_q << 1;
          if (cnt_q == '0) state_q <= S_CMP;
          else             cnt_q   <= cnt_q - 1'b1;
        end
        S_CMP: begin
          // Dot squared reaches the norm product: clamp to one
          if (ge) begin
            root_q  <= ROOT_W'(COS_ONE);
            state_q <= S_DONE;
          end else begin
            quo_q   <= '0;
            cnt_q   <= 6'(QUO_W - 1);
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          work_q <= ge ? sum[W-1:0] : work_q << 1;
          quo_q  <= {quo_q[QUO_W-2:0], ge};
          if (cnt_q == '0) begin
            work_q  <= W'({quo_q[QUO_W-2:0], ge});
            root_q  <= '0;
            bit_q   <= ROOT_W'(1) << (QUO_W - 2);
            cnt_q   <= 6'(QUO_W / 2 - 1);
            state_q <= S_SQRT;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        S_SQRT: begin
          if (ge) begin
            work_q <= sum[W-1:0];
            root_q <= (root_q >> 1) | bit_q;
          end else begin
            root_q <= root_q >> 1;
          end
          bit_q <= bit_q >> 2;
          if (cnt_q == '0) state_q <= S_DONE;
          else             cnt_q   <= cnt_q - 1'b1;
        end
        S_DONE:  state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign rsp_o.done = (state_q == S_DONE);
  assign rsp_o.root = root_q[DIST_BITS-1:0];

endmodule

`default_nettype wire

// ===== hw/rtl/vector_distance_unit_core.sv =====
// Streaming vector distance unit. Each input item carries one element pair of
// two signed 16-bit vectors with a last mark per vector; the unit keeps the sum
// of absolute differences, the sum of squared differences, the dot product and
// both squared norms. When either last mark is set one result item follows:
// L1 distance, L2 distance (8 fraction bits) or cosine similarity (Q2.14,
// clamped to +/-1.0), picked by the metric register as it stands at the close,
// then all sums clear. Status reports a length mismatch, a zero norm under
// cosine, or more than MAX_LEN pairs; distance is 0 whenever status is not ok.
// Sequence: an item is taken, then its four products pass through the single
// shared 17x17 multiplier before the next item is taken. A closing item needs no
// more arithmetic for L1 and errors; L2 takes 31 root steps and cosine two 43-step
// shift-add multiplies, a 28-step divide and a 14-step root, all on one shared
// 88-bit adder. A finished result waits in the output register while the next
// item is accepted; a second close waits for that register.
// There is no clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module vector_distance_unit_core import vdu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  vdu_in_if.sink    in_i,
  vdu_out_if.source out_o,
  vdu_cfg_if.sink   cfg_i
);

  typedef enum logic [2:0] {
    S_IDLE, S_ACC, S_CLOSE, S_WAIT, S_OUT
  } state_e;

  state_e                      state_q;
  logic [1:0]                  step_q;
  logic [1:0]                  metric_q;
  logic signed [ELEM_BITS-1:0] a_q, b_q;
  logic                        la_q, lb_q;
  logic [DIST_BITS-1:0]        res_dist_q;
  status_e                     res_st_q;
  out_item_t                   out_q;
  logic                        out_vld_q;

  acc_ctl_t                acc_ctl;
  cls_req_t                cls_req;
  cls_rsp_t                cls_rsp;
  logic [ABS_W-1:0]        abs_sum;
  logic [SQ_W-1:0]         sq_sum;
  logic signed [DOT_W-1:0] dot_sum;
  logic [NRM_W-1:0]        na_sum, nb_sum;
  logic [CNT_BITS-1:0]     count;
  logic [MAG_W-1:0]        dmag;

  logic    in_acc, out_free, out_load;
  logic    need_unit;
  status_e close_st;

  assign in_acc   = in_i.valid & in_i.ready;
  assign out_free = !out_vld_q || out_o.ready;
  assign out_load = (state_q == S_OUT) && out_free;
  assign dmag     = dot_sum[DOT_W-1] ? MAG_W'(-dot_sum) : MAG_W'(dot_sum);

  // Take configuration at any time; the user must write only while idle, which the block itself does not enforce
  assign cfg_i.ready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)          metric_q <= MET_L1;
    else if (cfg_i.valid) metric_q <= cfg_i.data;
  end

  // Decide the close: mismatch first, then length, then zero norm under cosine
  always_comb begin
    need_unit = 1'b0;
    close_st  = ST_OK;
    if (la_q != lb_q) begin
      close_st = ST_MISMATCH;
    end else if (count > CNT_BITS'(MAX_LEN)) begin
      close_st = ST_TOO_LONG;
    end else if (metric_q == MET_L1) begin
      need_unit = 1'b0;
    end else if (metric_q == MET_L2) begin
      need_unit = 1'b1;
    end else if (na_sum == '0 || nb_sum == '0) begin
      close_st = ST_ZERO_NORM;
    end else begin
      need_unit = 1'b1;
    end
  end

  assign acc_ctl.step_en = (state_q == S_ACC);
  assign acc_ctl.step    = step_q;
  assign acc_ctl.clr     = out_load;

  assign cls_req.start  = (state_q == S_CLOSE) && need_unit;
  assign cls_req.cosine = metric_q[1];

  assign in_i.ready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      step_q     <= '0;
      a_q        <= '0;
      b_q        <= '0;
      la_q       <= 1'b0;
      lb_q       <= 1'b0;
      res_dist_q <= '0;
      res_st_q   <= ST_OK;
      out_vld_q  <= 1'b0;
      out_q      <= '0;
    end else begin
      // Load a new result or drop the one just taken
      if (out_load)                      out_vld_q <= 1'b1;
      else if (out_vld_q && out_o.ready) out_vld_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            a_q     <= in_i.data.elem_a;
            b_q     <= in_i.data.elem_b;
            la_q    <= in_i.data.a_last;
            lb_q    <= in_i.data.b_last;
            step_q  <= '0;
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          step_q <= step_q + 1'b1;
          if (step_q == 2'd3) state_q <= (la_q || lb_q) ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          res_st_q   <= close_st;
          res_dist_q <= (close_st == ST_OK && metric_q == MET_L1) ?
                        DIST_BITS'(abs_sum) : '0;
          state_q    <= need_unit ? S_WAIT : S_OUT;
        end
        S_WAIT: begin
          if (cls_rsp.done) begin
            // Apply the sign of the dot product under cosine
            res_dist_q <= (metric_q[1] && dot_sum[DOT_W-1]) ?
                          (~cls_rsp.root + 1'b1) : cls_rsp.root;
            state_q    <= S_OUT;
          end
        end
        S_OUT: begin
          // Hold until the output register is free, then drop the sums
          if (out_free) begin
            out_q.distance <= res_dist_q;
            out_q.status   <= res_st_q;
            state_q        <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;

  vdu_acc u_acc (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (acc_ctl),
    .a_i       (a_q),
    .b_i       (b_q),
    .abs_sum_o (abs_sum),
    .sq_sum_o  (sq_sum),
    .dot_sum_o (dot_sum),
    .na_sum_o  (na_sum),
    .nb_sum_o  (nb_sum),
    .count_o   (count)
  );

  vdu_close u_close (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (cls_req),
    .sq_i   (sq_sum),
    .dmag_i (dmag),
    .na_i   (na_sum),
    .nb_i   (nb_sum),
    .rsp_o  (cls_rsp)
  );

  // An accepted item keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !in_i.ready)
    else $error("input ready right after an accepted item");

  // Error results carry a zero distance
  a_err_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status != ST_OK) |-> (out_q.distance == '0))
    else $error("non-zero distance with error status");

  // The closing unit answers only while the sequencer waits for it
  a_done_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cls_rsp.done |-> (state_q == S_WAIT))
    else $error("closing unit done outside wait state");

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import vdu_pkg::*;

  // Metric codes beyond the two the package names
  localparam logic [1:0] MET_COS    = 2'd2;
  localparam logic [1:0] MET_SPARE  = 2'd3;
  localparam int         SETTLE_CYC = 200;   // longer than a cosine close

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  vdu_in_if  in_if();
  vdu_out_if out_if();
  vdu_cfg_if cfg_if();

  vector_distance_unit_core DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  // Expected distance results, oldest first
  out_item_t pending_results[$];
  int        err_count = 0;
  bit        src_idle_en = 1'b1;
  bit        snk_stall_en = 1'b1;

  // Own copy of the metric register and the running sums
  logic [1:0]      metric_q;
  longint unsigned abs_sum, sq_sum, norm_a, norm_b;
  longint          dot_acc;
  int              pair_count;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    out_if.ready = 1'b0;
  end

  // Hard stop, far beyond the slowest correct run
  initial begin
    #4000000;
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned r, bt;
    r = 0;
    bt = 64'd1 << 62;
    while (bt > x) bt >>= 2;
    while (bt != 0) begin
      if (x >= r + bt) begin
        x -= r + bt;
        r = (r >> 1) + bt;
      end else begin
        r >>= 1;
      end
      bt >>= 2;
    end
    return r;
  endfunction

  // Cosine magnitude in Q2.14: largest r with r^2 * na*nb <= 2^28 * dot^2
  function automatic int cosine_mag();
    logic [127:0] p, q, rhs;
    longint unsigned d;
    int r, t, bt;
    d = (dot_acc < 0) ? longint'(-dot_acc) : longint'(dot_acc);
    p = 128'(norm_a) * 128'(norm_b);
    q = 128'(d) * 128'(d);
    if (q >= p) return COS_ONE;
    rhs = q << 28;
    r = 0;
    for (bt = 8192; bt > 0; bt >>= 1) begin
      t = r | bt;
      if (p * 128'(t * t) <= rhs) r = t;
    end
    return r;
  endfunction

  function automatic void clear_sums();
    abs_sum = 0;
    sq_sum = 0;
    norm_a = 0;
    norm_b = 0;
    dot_acc = 0;
    pair_count = 0;
  endfunction

  // Accumulate one element pair; return 1 and the result when the pair closes
  function automatic bit predict_pair(in_item_t it, output out_item_t res);
    longint a, b, ad;
    longint unsigned res_dist, m;
    status_e st;
    a = it.elem_a;
    b = it.elem_b;
    res = '0;
    if (pair_count < MAX_LEN) begin
      ad = (a > b) ? a - b : b - a;
      abs_sum += ad;
      sq_sum += ad * ad;
      dot_acc += a * b;
      norm_a += a * a;
      norm_b += b * b;
    end
    if (pair_count <= MAX_LEN) pair_count++;
    if (!it.a_last && !it.b_last) return 1'b0;
    res_dist = 0;
    st = ST_OK;
    if (it.a_last != it.b_last) begin
      st = ST_MISMATCH;
    end else if (pair_count > MAX_LEN) begin
      st = ST_TOO_LONG;
    end else if (metric_q == MET_L1) begin
      res_dist = (abs_sum > 64'd1073741823) ? 64'd1073741823 : abs_sum;
    end else if (metric_q == MET_L2) begin
      if (sq_sum >= (64'd1 << 44)) res_dist = 64'd1073741823;
      else res_dist = int_sqrt(sq_sum << 16);
      if (res_dist > 64'd1073741823) res_dist = 64'd1073741823;
    end else if (norm_a == 0 || norm_b == 0) begin
      st = ST_ZERO_NORM;
    end else begin
      m = cosine_mag();
      res_dist = (dot_acc < 0) ? -m : m;
    end
    res.distance = res_dist[DIST_BITS-1:0];
    res.status = st;
    clear_sums();
    return 1'b1;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    err_count++;
    $display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Sink side: stall at random, check each accepted result item
  always @(negedge clk_i) begin
    out_if.ready <= !snk_stall_en || ($urandom_range(99) >= 35);
  end

  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", out_if.data.distance, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_if.data.distance !== want.distance)
          report_mismatch("distance", out_if.data.distance, want.distance);
        if (out_if.data.status !== want.status)
          report_mismatch("status", out_if.data.status, want.status);
      end
    end
  end

  // Offer one item, hold it until accepted, then predict; valid stays high
  task automatic send_item(in_item_t it);
    out_item_t res;
    @(negedge clk_i);
    while (src_idle_en && $urandom_range(99) < 35) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (predict_pair(it, res)) pending_results.push_back(res);
  endtask

  task automatic send_pair(int a, int b, bit la, bit lb);
    in_item_t it;
    it.elem_a = a[15:0];
    it.elem_b = b[15:0];
    it.a_last = la;
    it.b_last = lb;
    send_item(it);
  endtask

  // Pause the source until every result is in, then let the closing math settle
  task automatic drain();
    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_metric(logic [1:0] m);
    drain();
    @(negedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    metric_q = m;
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  function automatic int rand_elem();
    case ($urandom_range(7))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(64) - 32;
      default: return int'($signed($urandom() & 32'hFFFF)) - ($urandom() & 32'h1 ? 0 : 0);
    endcase
  endfunction

  task automatic test_l1_l2_directed();
    write_metric(MET_L1);
    send_pair(-32768, 32767, 1, 1);
    send_pair(32767, -32768, 0, 0);
    send_pair(-32768, 32767, 1, 1);
    send_pair(5, 3, 1, 0);                 // length mismatch, a ends first
    send_pair(5, 3, 0, 1);                 // length mismatch, b ends first
    send_pair(0, 0, 1, 1);
    write_metric(MET_L2);
    send_pair(-32768, 32767, 0, 0);
    send_pair(3, -1, 1, 1);
    send_pair(1, 0, 1, 1);
  endtask

  task automatic test_cosine_directed();
    write_metric(MET_COS);
    send_pair(0, 7, 0, 0);                 // zero norm on the first vector
    send_pair(0, -7, 1, 1);
    send_pair(9, 0, 1, 1);                 // zero norm on the second vector
    send_pair(-32768, -32768, 0, 0);       // parallel: clamps at +1.0
    send_pair(32767, 32767, 1, 1);
    send_pair(-32768, 32767, 1, 1);        // opposite: -1.0
    send_pair(1, 0, 0, 0);                 // orthogonal
    send_pair(0, 1, 1, 1);
    write_metric(MET_SPARE);               // unassigned code decodes as cosine
    send_pair(3, 4, 0, 0);
    send_pair(4, 3, 1, 1);
    send_pair(2, 0, 1, 0);
  endtask

  // Vectors at exactly MAX_LEN pairs, then past it
  task automatic test_length_limit();
    write_metric(MET_L1);
    for (int n = 1; n <= MAX_LEN; n++)
      send_pair(rand_elem(), rand_elem(), n == MAX_LEN, n == MAX_LEN);
    for (int n = 1; n <= MAX_LEN + 3; n++)
      send_pair(rand_elem(), rand_elem(), n == MAX_LEN + 3, n == MAX_LEN + 3);
    write_metric(MET_COS);
    for (int n = 1; n <= MAX_LEN + 1; n++)
      send_pair(32767, -32768, n == MAX_LEN + 1, n == MAX_LEN + 1);
  endtask

  // Well-formed vector pairs of random length; a few end on one side only
  task automatic random_vectors(int n_items);
    int sent, len, a;
    bit mm, mode;
    sent = 0;
    while (sent < n_items) begin
      len = ($urandom_range(19) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      mm = ($urandom_range(9) == 0);
      mode = $urandom_range(1);
      for (int i = 1; i <= len; i++) begin
        a = rand_elem();
        // correlated pairs push cosine towards the clamp
        if (mode) send_pair(a, a + $urandom_range(8) - 4, i == len, i == len && !mm);
        else send_pair(a, rand_elem(), i == len, (i == len) ^ (mm && i == len - 1));
        sent++;
      end
      if (mm) send_pair(rand_elem(), rand_elem(), 1, 1);
    end
  endtask

  task automatic test_random();
    logic [1:0] plan[5] = '{MET_L1, MET_L2, MET_COS, MET_SPARE, MET_COS};
    foreach (plan[k]) begin
      write_metric(plan[k]);
      random_vectors(200);
    end
    // one stretch with no idling on either side
    src_idle_en = 1'b0;
    snk_stall_en = 1'b0;
    write_metric(MET_L2);
    random_vectors(100);
    src_idle_en = 1'b1;
    snk_stall_en = 1'b1;
  endtask

  initial begin
    metric_q = MET_L1;
    clear_sums();
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_l1_l2_directed();
    test_cosine_directed();
    test_random();
    test_length_limit();
    drain();
    if (err_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== vector_distance_unit_core.f =====
hw/rtl/vdu_pkg.sv
hw/rtl/vdu_if.sv
hw/rtl/vdu_acc.sv
hw/rtl/vdu_close.sv
hw/rtl/vector_distance_unit_core.sv
tb/sv/tb.sv
